// ===== hdl/bbr_pkg.sv =====
`default_nettype none
package bbr_pkg;

  // default build parameters
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // object tag placed in the upper half of the tagged id
  localparam logic [31:0] TAG_HIGH = 32'h5041_5254;

  // sine polynomial coefficients, Q30
  localparam logic [31:0] SIN_A = 32'd1686629713;
  localparam logic [31:0] SIN_B = 32'd688904866;
  localparam logic [31:0] SIN_C = 32'd76016977;

  // unit length in Q2.30
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // squared length at or below which a camera vector counts as degenerate
  localparam logic [31:0] SMALL_SQ = 32'd2;

  // register map
  typedef enum logic [2:0] {
    REG_RIGHT_X = 3'd0,
    REG_RIGHT_Y = 3'd1,
    REG_RIGHT_Z = 3'd2,
    REG_UP_X    = 3'd3,
    REG_UP_Y    = 3'd4,
    REG_UP_Z    = 3'd5
  } reg_idx_t;

  // raw camera vectors, Q2.14
  typedef struct packed {
    logic [2:0][15:0] right;
    logic [2:0][15:0] up;
  } bbr_cam_t;

  // normalised camera vectors, signed Q2.30
  typedef struct packed {
    logic [2:0][31:0] right;
    logic [2:0][31:0] up;
  } bbr_coef_t;

  // normaliser sequencer states
  typedef enum logic [2:0] {
    NS_SQ,
    NS_SQRT,
    NS_DSET,
    NS_DIV,
    NS_DONE
  } norm_state_t;

endpackage
`default_nettype wire

// ===== hdl/bbr_regs.sv =====
`default_nettype none
module bbr_regs
  import bbr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output bbr_cam_t         cam_o,
  output logic             wr_o
);

  localparam logic [15:0] ONE_RAW = 16'(32'd1 << FRAC_BITS);

  bbr_cam_t cam_r;
  reg_idx_t idx;
  logic     wr;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign wr_o       = wr;
  assign cam_o      = cam_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.right <= {16'd0, 16'd0, ONE_RAW};
      cam_r.up    <= {16'd0, ONE_RAW, 16'd0};
    end else if (wr) begin
      case (idx)
        REG_RIGHT_X: cam_r.right[0] <= cfg_pwdata[15:0];
        REG_RIGHT_Y: cam_r.right[1] <= cfg_pwdata[15:0];
        REG_RIGHT_Z: cam_r.right[2] <= cfg_pwdata[15:0];
        REG_UP_X:    cam_r.up[0]    <= cfg_pwdata[15:0];
        REG_UP_Y:    cam_r.up[1]    <= cfg_pwdata[15:0];
        REG_UP_Z:    cam_r.up[2]    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_RIGHT_X: cfg_prdata = {16'd0, cam_r.right[0]};
      REG_RIGHT_Y: cfg_prdata = {16'd0, cam_r.right[1]};
      REG_RIGHT_Z: cfg_prdata = {16'd0, cam_r.right[2]};
      REG_UP_X:    cfg_prdata = {16'd0, cam_r.up[0]};
      REG_UP_Y:    cfg_prdata = {16'd0, cam_r.up[1]};
      REG_UP_Z:    cfg_prdata = {16'd0, cam_r.up[2]};
      default:     cfg_prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/bbr_norm.sv =====
`default_nettype none
module bbr_norm
  import bbr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire bbr_cam_t cam_i,
  input  wire logic     start_i,
  output bbr_coef_t     coef_o,
  output logic          busy_o
);

  norm_state_t st_r, st_nxt;
  logic        vsel_r, vsel_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [31:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [30:0] num_r, num_nxt;
  logic [31:0] drem_r, drem_nxt;
  logic [30:0] quo_r, quo_nxt;
  bbr_coef_t   coef_r, coef_nxt;

  logic [15:0]        x;
  logic signed [31:0] xe;
  logic [31:0]        sqx, sq_sum;
  logic [15:0]        ax;
  logic [35:0]        rem_n, trial;
  logic [61:0]        nn;
  logic [32:0]        dr_n;
  logic [30:0]        qf;
  logic [31:0]        cval;

  assign coef_o = coef_r;
  assign busy_o = (st_r != NS_DONE);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= NS_SQ;
      vsel_r <= 1'b0;
      idx_r  <= 2'd0;
      cnt_r  <= 5'd0;
      sq_r   <= 32'd0;
    end else begin
      st_r   <= st_nxt;
      vsel_r <= vsel_nxt;
      idx_r  <= idx_nxt;
      cnt_r  <= cnt_nxt;
      sq_r   <= sq_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    num_r  <= num_nxt;
    drem_r <= drem_nxt;
    quo_r  <= quo_nxt;
    coef_r <= coef_nxt;
  end

  // shared arithmetic
  always_comb begin
    x      = vsel_r ? cam_i.up[idx_r] : cam_i.right[idx_r];
    xe     = 32'($signed(x));
    sqx    = xe * xe;
    sq_sum = sq_r + sqx;
    ax     = x[15] ? 16'(-$signed(x)) : x;
    // one root digit per cycle
    rem_n  = {rem_r, rad_r[31:30]};
    trial  = {2'b00, root_r, 2'b01};
    // rounded dividend: |x| << 46 plus half the length
    nn     = {ax, 46'd0} + {31'd0, root_r[31:1]};
    // one quotient bit per cycle
    dr_n   = {drem_r, num_r[30]};
  end

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    vsel_nxt = vsel_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    sq_nxt   = sq_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    num_nxt  = num_r;
    drem_nxt = drem_r;
    quo_nxt  = quo_r;
    coef_nxt = coef_r;
    qf       = 31'd0;
    cval     = 32'd0;

    case (st_r)
      NS_SQ: begin
        sq_nxt  = sq_sum;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          idx_nxt = 2'd0;
          if (sq_sum <= SMALL_SQ) begin
            // degenerate: unit X for right, unit Y for up
            if (vsel_r) begin
              coef_nxt.up = {32'd0, Q30_ONE, 32'd0};
              st_nxt      = NS_DONE;
            end else begin
              coef_nxt.right = {32'd0, 32'd0, Q30_ONE};
              vsel_nxt       = 1'b1;
              sq_nxt         = 32'd0;
            end
          end else begin
            rad_nxt  = sq_sum;
            rem_nxt  = 34'd0;
            root_nxt = 32'd0;
            cnt_nxt  = 5'd0;
            st_nxt   = NS_SQRT;
          end
        end
      end
      NS_SQRT: begin
        rad_nxt = {rad_r[29:0], 2'b00};
        if (rem_n >= trial) begin
          rem_nxt  = 34'(rem_n - trial);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt  = rem_n[33:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          st_nxt  = NS_DSET;
          idx_nxt = 2'd0;
        end
      end
      NS_DSET: begin
        drem_nxt = {1'b0, nn[61:31]};
        num_nxt  = nn[30:0];
        quo_nxt  = 31'd0;
        cnt_nxt  = 5'd0;
        st_nxt   = NS_DIV;
      end
      NS_DIV: begin
        num_nxt = {num_r[29:0], 1'b0};
        if (dr_n >= {1'b0, root_r}) begin
          drem_nxt = 32'(dr_n - {1'b0, root_r});
          quo_nxt  = {quo_r[29:0], 1'b1};
        end else begin
          drem_nxt = dr_n[31:0];
          quo_nxt  = {quo_r[29:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          qf   = quo_nxt;
          cval = x[15] ? 32'(-{1'b0, qf}) : {1'b0, qf};
          if (vsel_r) coef_nxt.up[idx_r] = cval;
          else        coef_nxt.right[idx_r] = cval;
          if (idx_r == 2'd2) begin
            idx_nxt = 2'd0;
            if (vsel_r) begin
              st_nxt = NS_DONE;
            end else begin
              vsel_nxt = 1'b1;
              sq_nxt   = 32'd0;
              st_nxt   = NS_SQ;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
            st_nxt  = NS_DSET;
          end
        end
      end
      NS_DONE: ;
      default: st_nxt = NS_SQ;
    endcase

    // any register write restarts both vectors
    if (start_i) begin
      st_nxt   = NS_SQ;
      vsel_nxt = 1'b0;
      idx_nxt  = 2'd0;
      sq_nxt   = 32'd0;
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == NS_DONE && !start_i) |=> (st_r == NS_DONE))
    else $error("normaliser left idle without a register write");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |=> (st_r == NS_SQ && !vsel_r && idx_r == 2'd0 && sq_r == 32'd0))
    else $error("register write did not restart normalisation");

  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == NS_SQRT && cnt_r == 5'd31 && !start_i) |=> (st_r == NS_DSET))
    else $error("square root did not finish after 32 digits");

endmodule
`default_nettype wire

// ===== hdl/bbr_pipe.sv =====
`default_nettype none
module bbr_pipe
  import bbr_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        hold_i,
  input  wire bbr_coef_t   coef_i,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] angle_i,
  input  wire logic [15:0] scale_i,
  input  wire logic [31:0] group_id_i,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [5:0][23:0] axis_o,
  output logic [31:0]      group_id_o
);

  localparam int NST = 10;
  localparam int SH  = 38 - FRAC_BITS;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // round half away from zero, Q60 to Q30
  function automatic logic signed [35:0] rnd30(input logic signed [64:0] v);
    logic [64:0] m;
    logic [64:0] r;
    m = v[64] ? 65'(-v) : 65'(v);
    r = (m + (65'd1 << 29)) >> 30;
    return v[64] ? 36'(-r) : 36'(r);
  endfunction

  // round half away from zero to output precision, then saturate
  function automatic logic [23:0] rnd_sat(input logic signed [52:0] v);
    logic [52:0] m;
    logic [52:0] r;
    logic [23:0] o;
    m = v[52] ? 53'(-v) : 53'(v);
    r = (m + (53'd1 << (SH - 1))) >> SH;
    if (!v[52]) o = (r > 53'd8388607) ? 24'h7F_FFFF : r[23:0];
    else        o = (r > 53'd8388608) ? 24'h80_0000 : 24'(-r);
    return o;
  endfunction

  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;
  logic           in_fire;

  // per-lane phase: lane 0 sine, lane 1 cosine
  logic [31:0]      ph   [2];
  logic [1:0][30:0] t_r  [4];
  logic [1:0][1:0]  q_r  [4];
  logic [30:0]      t2_r [2];
  logic [30:0]      t2b_r[2];
  logic [31:0]      pu_r [2];
  logic [31:0]      pv_r [2];
  logic signed [31:0] sc_r[2];
  logic signed [63:0] prc_r[3], pus_r[3], puc_r[3], prs_r[3];
  logic signed [64:0] sum_r[6];
  logic signed [35:0] rr_r [6];
  logic signed [52:0] ps_r [6];
  logic [23:0]        ax_r [6];
  logic [15:0]        scl_r[8];
  logic [31:0]        gid_r[NST];

  // stall chain: a stage takes data when empty or when its successor moves
  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready  = rdy[0] && !hold_i;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = vld_r[NST-1];
  assign group_id_o = gid_r[NST-1];

  always_comb begin
    ph[0] = (({16'd0, angle_i} & AMASK) << (32 - ANGLE_BITS));
    ph[1] = ph[0] + 32'h4000_0000;
    for (int i = 0; i < 6; i++) axis_o[i] = ax_r[i];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_fire;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // data path
  always_ff @(posedge clk) begin
    // stage 0: quadrant and mirrored fraction
    if (rdy[0]) begin
      for (int l = 0; l < 2; l++) begin
        q_r[0][l] <= ph[l][31:30];
        t_r[0][l] <= ph[l][30] ? (31'h4000_0000 - {1'b0, ph[l][29:0]})
                               : {1'b0, ph[l][29:0]};
      end
      scl_r[0] <= scale_i;
      gid_r[0] <= group_id_i;
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        t_r[k] <= t_r[k-1];
        q_r[k] <= q_r[k-1];
      end
    end
    for (int k = 1; k < 8; k++) begin
      if (rdy[k]) scl_r[k] <= scl_r[k-1];
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) gid_r[k] <= gid_r[k-1];
    end
    // stages 1 to 4: sine polynomial
    if (rdy[1]) begin
      for (int l = 0; l < 2; l++) begin
        t2_r[l] <= 31'((64'(t_r[0][l]) * 64'(t_r[0][l])) >> 30);
      end
    end
    if (rdy[2]) begin
      for (int l = 0; l < 2; l++) begin
        pu_r[l]  <= SIN_B - 32'((64'(t2_r[l]) * 64'(SIN_C)) >> 30);
        t2b_r[l] <= t2_r[l];
      end
    end
    if (rdy[3]) begin
      for (int l = 0; l < 2; l++) begin
        pv_r[l] <= SIN_A - 32'((64'(t2b_r[l]) * 64'(pu_r[l])) >> 30);
      end
    end
    if (rdy[4]) begin
      for (int l = 0; l < 2; l++) begin
        sc_r[l] <= q_r[3][l][1]
                 ? -$signed(32'((64'(t_r[3][l]) * 64'(pv_r[l])) >> 30))
                 :  $signed(32'((64'(t_r[3][l]) * 64'(pv_r[l])) >> 30));
      end
    end
    // stage 5: rotation products
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        prc_r[i] <= $signed(coef_i.right[i]) * sc_r[1];
        pus_r[i] <= $signed(coef_i.up[i])    * sc_r[0];
        puc_r[i] <= $signed(coef_i.up[i])    * sc_r[1];
        prs_r[i] <= $signed(coef_i.right[i]) * sc_r[0];
      end
    end
    // stage 6: sums
    if (rdy[6]) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i]   <= prc_r[i] + pus_r[i];
        sum_r[3+i] <= puc_r[i] - prs_r[i];
      end
    end
    // stage 7: back to Q30
    if (rdy[7]) begin
      for (int i = 0; i < 6; i++) rr_r[i] <= rnd30(sum_r[i]);
    end
    // stage 8: scale by particle size
    if (rdy[8]) begin
      for (int i = 0; i < 6; i++) ps_r[i] <= rr_r[i] * $signed({1'b0, scl_r[7]});
    end
    // stage 9: output register
    if (rdy[9]) begin
      for (int i = 0; i < 6; i++) ax_r[i] <= rnd_sat(ps_r[i]);
    end
  end

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_r[0])
    else $error("accepted transaction not captured");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r[1]) |-> $past(vld_r[0]))
    else $error("stage one valid without a predecessor");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(vld_r[NST-2]))
    else $error("result appeared without a transaction behind it");

endmodule
`default_nettype wire

// ===== hdl/billboard_axis_rotator.sv =====
`default_nettype none
// Billboard axis rotator.
// Register port (APB style, always ready): six 16-bit Q2.14 camera
// components at byte addresses 0x00..0x14 (right x/y/z, up x/y/z).
// Every register write, and reset, starts a normalisation of both camera
// vectors: per vector the three squares are summed, then a square root
// and three divisions follow unless it is degenerate. in_tready is low meanwhile.
// Input stream: one particle per transaction (angle, scale, group id).
// Output stream: six rotated, scaled axis components in Q10.14 and the
// tagged object id, one transaction per input transaction, in order.
// Throughput is one particle per cycle while the receiver is ready and no
// normalisation runs; results pass through the ten-stage arithmetic pipeline
// (sine polynomial, rotation products, rounding, scaling).
// When the receiver stalls, each stage holds its data and empty stages
// keep filling, so input is taken until the pipeline is full.
// Reset empties the pipeline and restores the default camera axes.
module billboard_axis_rotator
  import bbr_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic      [31:0]  cfg_prdata,
  output logic              cfg_pready,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // angle[15:0], scale[31:16], group_id[63:32]
  input  wire logic [63:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // axis_right_x, axis_right_y, axis_right_z, axis_up_x, axis_up_y,
  // axis_up_z (24 bits each from bit 0), tagged_id[207:144]
  output logic      [207:0] out_tdata
);

  bbr_cam_t        cam;
  bbr_coef_t       coef;
  logic            cfg_wr;
  logic            busy;
  logic [5:0][23:0] axis;
  logic [31:0]     gid;

  bbr_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cam_o       (cam),
    .wr_o        (cfg_wr)
  );

  bbr_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .cam_i   (cam),
    .start_i (cfg_wr),
    .coef_o  (coef),
    .busy_o  (busy)
  );

  bbr_pipe #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_i     (busy),
    .coef_i     (coef),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .angle_i    (in_tdata[15:0]),
    .scale_i    (in_tdata[31:16]),
    .group_id_i (in_tdata[63:32]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .axis_o     (axis),
    .group_id_o (gid)
  );

  // result packing
  assign out_tdata = {TAG_HIGH, gid, axis};

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
  import bbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_SPARE_LO = 6;     // unmapped register slots, writes ignored
  localparam int REG_SPARE_HI = 7;
  localparam int IDLE_LIMIT   = 3000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 30;    // pipeline latency plus margin

  // Expected billboard axes, computed from the camera registers
  class billboard_scoreboard;
    logic [15:0] cam [6];
    logic [207:0] pending [$];
    int errors;

    function new();
      foreach (cam[i]) cam[i] = '0;
      cam[REG_RIGHT_X] = 16'h4000;
      cam[REG_UP_Y]    = 16'h4000;
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [15:0] val);
      if (idx <= int'(REG_UP_Z)) cam[idx] = val;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // round half away from zero
    function longint round_shift(longint v, int sh);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // unit vector in Q2.30; near-zero vectors fall back to a default axis
    function void unit_vec(int base, int dflt, output longint c [3]);
      longint x [3];
      longint unsigned sq, len, m;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        x[i] = longint'($signed(cam[base + i]));
        sq += longint'(x[i] * x[i]);
      end
      if (sq <= 2) begin
        for (int i = 0; i < 3; i++) c[i] = (i == dflt) ? longint'(Q30_ONE) : 0;
        return;
      end
      len = isqrt(sq << 32);
      for (int i = 0; i < 3; i++) begin
        m = longint'((x[i] < 0) ? -x[i] : x[i]) << 46;
        m = (m + (len >> 1)) / len;
        c[i] = (x[i] < 0) ? -longint'(m) : longint'(m);
      end
    endfunction

    // polynomial sine of a 32-bit phase, Q2.30
    function longint sine(logic [31:0] p);
      longint unsigned t, t2, u, v, s;
      t = {34'd0, p[29:0]};
      if (p[30]) t = (64'd1 << 30) - t;
      t2 = (t * t) >> 30;
      u = 64'(SIN_B) - ((t2 * 64'(SIN_C)) >> 30);
      v = 64'(SIN_A) - ((t2 * u) >> 30);
      s = (t * v) >> 30;
      return p[31] ? -longint'(s) : longint'(s);
    endfunction

    function logic [23:0] axis(longint a, longint ca, longint b, longint cb,
                               logic [15:0] scale);
      longint r, o;
      r = round_shift(a * ca + b * cb, 30);
      o = round_shift(r * longint'({48'd0, scale}), 38 - FRAC_BITS_DEF);
      if (o > 8388607) o = 8388607;
      if (o < -8388608) o = -8388608;
      return o[23:0];
    endfunction

    function void note_particle(logic [63:0] d);
      longint rv [3], uv [3];
      longint s, c;
      logic [207:0] e;
      unit_vec(0, 0, rv);
      unit_vec(3, 1, uv);
      s = sine({d[15:0], 16'd0});
      c = sine({d[15:0], 16'd0} + 32'h4000_0000);
      for (int i = 0; i < 3; i++) begin
        e[24*i +: 24]     = axis(rv[i], c, uv[i], s, d[31:16]);
        e[24*(3+i) +: 24] = axis(uv[i], c, rv[i], -s, d[31:16]);
      end
      e[207:144] = {TAG_HIGH, d[63:32]};
      pending = {pending, e};
    endfunction

    function void check_axes(logic [207:0] got);
      logic [207:0] e;
      string names [7];
      bit bad;
      names = '{"right_x", "right_y", "right_z", "up_x", "up_y", "up_z", "tagged_id"};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output transaction %h", got);
        return;
      end
      e = pending.pop_front();
      bad = 0;
      for (int i = 0; i < 6; i++)
        if (got[24*i +: 24] !== e[24*i +: 24]) begin
          bad = 1;
          if (errors < 10)
            $display("%s: expected %h got %h", names[i], e[24*i +: 24], got[24*i +: 24]);
        end
      if (got[207:144] !== e[207:144]) begin
        bad = 1;
        if (errors < 10)
          $display("%s: expected %h got %h", names[6], e[207:144], got[207:144]);
      end
      if (bad) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [207:0] out_tdata;

  billboard_scoreboard sb;
  bit calm;            // phase without idling on either side
  int stall_left;
  int idle_cycles;

  always #1 clk = ~clk;

  billboard_axis_rotator i_dut (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  function int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (calm || k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check transactions and stall the receiver
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_axes(out_tdata);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_tready <= 1'b1;
    end
  end

  // watchdog on transaction activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [15:0] val);
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= 5'(4 * idx);
    cfg_pwdata <= {16'($urandom_range(0, 65535)), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_camera(logic [15:0] rx, ry, rz, ux, uy, uz);
    write_reg(REG_RIGHT_X, rx);
    write_reg(REG_RIGHT_Y, ry);
    write_reg(REG_RIGHT_Z, rz);
    write_reg(REG_UP_X, ux);
    write_reg(REG_UP_Y, uy);
    write_reg(REG_UP_Z, uz);
  endtask

  // one input transaction, with an optional gap in front
  task automatic send_particle(logic [15:0] angle, logic [15:0] scale, logic [31:0] gid);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {gid, scale, angle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_particle({gid, scale, angle});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [15:0] rand_comp();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return 16'($signed($urandom_range(0, 4)) - 2);
    if (k == 2) return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    return 16'($urandom_range(0, 65535));
  endfunction

  function logic [15:0] rand_angle();
    if ($urandom_range(0, 4) == 0)
      return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
    return 16'($urandom_range(0, 65535));
  endfunction

  function logic [15:0] rand_scale();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 16'($urandom_range(0, 2047));
    if (k < 7) return 16'($urandom_range(0, 1) ? 16'hffff : 16'h0000);
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [15:0] dir_angle [6];
    sb = new();
    calm = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    dir_angle = '{16'd0, 16'd1, 16'd16384, 16'd32768, 16'd49152, 16'hffff};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default camera, quadrant angles, scale and id extremes
    foreach (dir_angle[i]) send_particle(dir_angle[i], 16'h0100, 32'h0000_0000);
    send_particle(16'd8192, 16'hffff, 32'hffff_ffff);
    send_particle(16'd40000, 16'h0000, 32'ha5a5_5a5a);
    send_particle(16'hffff, 16'hffff, 32'h5a5a_a5a5);
    drain();

    // degenerate vectors fall back to default axes; spare slots ignored
    load_camera(16'h0001, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    write_reg(REG_SPARE_LO, 16'h1234);
    write_reg(REG_SPARE_HI, 16'h8000);
    send_particle(16'd5000, 16'h0200, 32'h1);
    send_particle(16'd60000, 16'hffff, 32'h2);
    drain();
    load_camera(16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'hffff, 16'h0001);
    send_particle(16'd12345, 16'h0100, 32'h3);
    send_particle(16'd0, 16'hffff, 32'h4);
    drain();

    // extreme components, saturating sizes
    load_camera(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    foreach (dir_angle[i]) send_particle(dir_angle[i], 16'hffff, 32'(i));
    drain();

    // random phases, each with its own camera
    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph % 4 == 3);
      load_camera(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
      repeat (100) send_particle(rand_angle(), rand_scale(), $urandom());
      drain();
    end

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== billboard_axis_rotator.f =====
hdl/bbr_pkg.sv
hdl/bbr_regs.sv
hdl/bbr_norm.sv
hdl/bbr_pipe.sv
hdl/billboard_axis_rotator.sv
tb/tb.sv
